@@ design/uart_register_file_rx_fifo_top_assert.svh @@
// ----------------------------------------------------------------------------
// UART register file assertion macros
// Shorthand for clocked implication checks with synchronous reset masking.
// ----------------------------------------------------------------------------
`ifndef UART_REGISTER_FILE_RX_FIFO_TOP_ASSERT_SVH
`define UART_REGISTER_FILE_RX_FIFO_TOP_ASSERT_SVH

// Same-cycle implication.
`define URF_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("urf assertion failed");

// Delayed implication: the consequent is checked after the antecedent.
`define URF_ASSERT_2CYC(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> ##2 (cons)) \
    else $error("urf assertion failed");

`endif

@@ design/urf_pkg.sv @@
// ----------------------------------------------------------------------------
// UART register file package
// Transfer types, register offsets, fixed register values and ID bytes.
// ----------------------------------------------------------------------------
`default_nettype none

package urf_pkg;

  typedef struct packed {
    logic [1:0]  action;
    logic [11:0] offset;
    logic [31:0] write_data;
    logic [7:0]  rx_char;
  } in_t;

  typedef struct packed {
    logic [31:0] read_data;
    logic        tx_valid;
    logic [7:0]  tx_char;
    logic        irq_pulse;
    logic        rx_overrun;
  } out_t;

  // Requests from the register decode to the receive FIFO
  typedef struct packed {
    logic       push;
    logic       pop;
    logic [7:0] wdata;
  } fifo_req_t;

  // FIFO status back to the register decode
  typedef struct packed {
    logic [7:0] rd_data;
    logic       empty;
    logic       full;
    logic       nonempty_nxt;
  } fifo_stat_t;

  localparam logic [1:0] ACT_READ  = 2'd0;
  localparam logic [1:0] ACT_WRITE = 2'd1;
  localparam logic [1:0] ACT_RX    = 2'd2;

  localparam logic [11:0] OFF_DR    = 12'h000;
  localparam logic [11:0] OFF_FR    = 12'h018;
  localparam logic [11:0] OFF_IBRD  = 12'h024;
  localparam logic [11:0] OFF_FBRD  = 12'h028;
  localparam logic [11:0] OFF_LCRH  = 12'h02C;
  localparam logic [11:0] OFF_CR    = 12'h030;
  localparam logic [11:0] OFF_IFLS  = 12'h034;
  localparam logic [11:0] OFF_IMSC  = 12'h038;
  localparam logic [11:0] OFF_RIS   = 12'h03C;
  localparam logic [11:0] OFF_MIS   = 12'h040;
  localparam logic [11:0] OFF_ICR   = 12'h044;

  localparam logic [31:0] VAL_IBRD  = 32'h0000_0002;
  localparam logic [31:0] VAL_FBRD  = 32'h0000_000B;
  localparam logic [31:0] VAL_LCRH  = 32'h0000_0070;
  localparam logic [31:0] VAL_CR    = 32'h0000_0301;
  localparam logic [31:0] VAL_IFLS  = 32'h0000_0000;

  localparam logic [31:0] FR_TXFE   = 32'h0000_0080;
  localparam logic [31:0] FR_RXFF   = 32'h0000_0040;
  localparam logic [31:0] FR_RXFE   = 32'h0000_0010;

  localparam int          RAW_W     = 11;
  localparam int          ST_RX_BIT = 4;
  localparam logic [10:0] RAW_RST   = 11'h020;

  function automatic logic [7:0] id_byte(input logic [2:0] idx);
    logic [7:0] b;
    case (idx)
      3'd0:    b = 8'h11;
      3'd1:    b = 8'h10;
      3'd2:    b = 8'h34;
      3'd3:    b = 8'h00;
      3'd4:    b = 8'h0D;
      3'd5:    b = 8'hF0;
      3'd6:    b = 8'h05;
      3'd7:    b = 8'hB1;
      default: b = 8'h00;
    endcase
    return b;
  endfunction

endpackage

`default_nettype wire

@@ design/urf_rx_fifo.sv @@
// ----------------------------------------------------------------------------
// UART receive FIFO
// Circular byte store with head/tail pointers and a prefetched head entry.
// ----------------------------------------------------------------------------
`default_nettype none

module urf_rx_fifo import urf_pkg::*; #(
  parameter int FIFO_DEPTH = 16,
  localparam int PTR_W = (FIFO_DEPTH > 2) ? $clog2(FIFO_DEPTH) : 1,
  localparam int CNT_W = $clog2(FIFO_DEPTH + 1)
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire fifo_req_t  req,
  output fifo_stat_t      stat
);

  logic [7:0]       mem [FIFO_DEPTH];
  logic [PTR_W-1:0] head_r, head_nxt;
  logic [PTR_W-1:0] tail_r, tail_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic [7:0]       rd_data_r;

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    return (p == PTR_W'(FIFO_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  always_comb begin
    head_nxt  = req.pop  ? ptr_inc(head_r) : head_r;
    tail_nxt  = req.push ? ptr_inc(tail_r) : tail_r;
    count_nxt = count_r + CNT_W'(req.push) - CNT_W'(req.pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r  <= '0;
      tail_r  <= '0;
      count_r <= '0;
    end else begin
      head_r  <= head_nxt;
      tail_r  <= tail_nxt;
      count_r <= count_nxt;
    end
  end

  // Keep the entry at the next head ready; forward a byte landing there
  always_ff @(posedge clk) begin
    if (req.push) begin
      mem[tail_r] <= req.wdata;
    end
    if (req.push && (tail_r == head_nxt)) begin
      rd_data_r <= req.wdata;
    end else begin
      rd_data_r <= mem[head_nxt];
    end
  end

  always_comb begin
    stat.rd_data      = rd_data_r;
    stat.empty        = (count_r == '0);
    stat.full         = (count_r == CNT_W'(FIFO_DEPTH));
    stat.nonempty_nxt = (count_nxt != '0);
  end

endmodule

`default_nettype wire

@@ design/uart_register_file_rx_fifo_top.sv @@
// ----------------------------------------------------------------------------
// UART register file with receive FIFO
// Bus reads and writes of the UART registers plus received-byte pushes.
// ----------------------------------------------------------------------------
//  Channel | Ports                      | Handshake
//  --------+----------------------------+----------------------------------
//  input   | start, busy, in_item       | transfer when start && !busy
//  result  | out_valid, out_item        | one-cycle strobe, no backpressure
//
//  One item per cycle; busy is never raised. A transfer is registered,
//  decoded and applied to the FIFO and status in the next cycle; its result
//  is on out_item for the cycle after that. The FIFO head entry is
//  prefetched from its memory so a data read pops the head byte without
//  waiting on a memory read. Synchronous reset empties the FIFO, clears
//  the mask and sets raw status to the TX bit; no clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none

`include "uart_register_file_rx_fifo_top_assert.svh"

module uart_register_file_rx_fifo_top import urf_pkg::*; #(
  parameter int FIFO_DEPTH = 16
) (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic start,
  output logic      busy,
  input  wire in_t  in_item,
  output logic      out_valid,
  output out_t      out_item
);

  logic             stg_valid_r;
  in_t              stg_item_r;
  logic             out_valid_r;
  out_t             out_item_r;
  out_t             out_nxt;
  logic [31:0]      mask_r, mask_nxt;
  logic [RAW_W-1:0] raw_r, raw_nxt;
  logic [RAW_W-1:0] raw_clr;
  logic             recomp;
  fifo_req_t        freq;
  fifo_stat_t       fstat;

  assign busy = 1'b0;

  urf_rx_fifo #(.FIFO_DEPTH(FIFO_DEPTH)) u_rx_fifo (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (freq),
    .stat  (fstat)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stg_valid_r <= 1'b0;
    end else begin
      stg_valid_r <= start && !busy;
    end
  end

  always_ff @(posedge clk) begin
    stg_item_r <= in_item;
  end

  always_comb begin
    out_nxt    = '0;
    recomp     = 1'b0;
    raw_clr    = '0;
    mask_nxt   = mask_r;
    freq.push  = 1'b0;
    freq.pop   = 1'b0;
    freq.wdata = stg_item_r.rx_char;
    if (stg_valid_r) begin
      case (stg_item_r.action)
        ACT_READ: begin
          case (stg_item_r.offset)
            OFF_DR: begin
              freq.pop = !fstat.empty;
              if (!fstat.empty) begin
                out_nxt.read_data = {24'h0, fstat.rd_data};
              end
              recomp = 1'b1;
            end
            OFF_FR: begin
              out_nxt.read_data = FR_TXFE;
              if (fstat.empty) begin
                out_nxt.read_data = FR_TXFE | FR_RXFE;
              end else if (fstat.full) begin
                out_nxt.read_data = FR_TXFE | FR_RXFF;
              end
            end
            OFF_IBRD: out_nxt.read_data = VAL_IBRD;
            OFF_FBRD: out_nxt.read_data = VAL_FBRD;
            OFF_LCRH: out_nxt.read_data = VAL_LCRH;
            OFF_CR:   out_nxt.read_data = VAL_CR;
            OFF_IFLS: out_nxt.read_data = VAL_IFLS;
            OFF_IMSC: out_nxt.read_data = mask_r;
            OFF_RIS:  out_nxt.read_data = {{(32-RAW_W){1'b0}}, raw_r};
            OFF_MIS:  out_nxt.read_data = {{(32-RAW_W){1'b0}}, raw_r & mask_r[RAW_W-1:0]};
            default: begin
              // ID window covers 0xFE0 through 0xFFC
              if ((stg_item_r.offset[11:5] == 7'h7F) && (stg_item_r.offset[4:0] <= 5'h1C)) begin
                out_nxt.read_data = {24'h0, id_byte(stg_item_r.offset[4:2])};
              end
            end
          endcase
        end
        ACT_WRITE: begin
          case (stg_item_r.offset)
            OFF_DR: begin
              out_nxt.tx_valid = 1'b1;
              out_nxt.tx_char  = stg_item_r.write_data[7:0];
            end
            OFF_IMSC: begin
              mask_nxt = stg_item_r.write_data;
              recomp   = 1'b1;
            end
            OFF_ICR: begin
              raw_clr = stg_item_r.write_data[RAW_W-1:0];
              recomp  = 1'b1;
            end
            default: ;
          endcase
        end
        ACT_RX: begin
          if (fstat.full) begin
            out_nxt.rx_overrun = 1'b1;
          end else begin
            freq.push = 1'b1;
            recomp    = 1'b1;
          end
        end
        default: ;
      endcase
    end

    raw_nxt = raw_r & ~raw_clr;
    if (recomp) begin
      raw_nxt[ST_RX_BIT] = fstat.nonempty_nxt;
    end
    out_nxt.irq_pulse = recomp && ((raw_nxt & mask_nxt[RAW_W-1:0]) != '0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      raw_r       <= RAW_RST;
      mask_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      raw_r       <= raw_nxt;
      mask_r      <= mask_nxt;
      out_valid_r <= stg_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    out_item_r <= out_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  `URF_ASSERT_2CYC(a_result_follows_transfer, clk, rst_n, start && !busy, out_valid)
  `URF_ASSERT_NOW(a_overrun_alone, clk, rst_n, out_valid && out_item.rx_overrun,
                  !out_item.tx_valid && !out_item.irq_pulse && (out_item.read_data == '0))
  `URF_ASSERT_NOW(a_irq_needs_mask, clk, rst_n, out_valid && out_item.irq_pulse,
                  mask_r != '0)
  `URF_ASSERT_NOW(a_fifo_flags, clk, rst_n, 1'b1, !(fstat.empty && fstat.full))

endmodule

`default_nettype wire
